/* hw/rtl/inverse_gaussian_sample_transform_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the inverse Gaussian sample transform.
// Each macro expands to a labelled concurrent assertion in simulation and to
// nothing in synthesis. The enclosing module must have clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef INVERSE_GAUSSIAN_SAMPLE_TRANSFORM_DEFINES_SVH
`define INVERSE_GAUSSIAN_SAMPLE_TRANSFORM_DEFINES_SVH
`ifndef SYNTHESIS
`define IGST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IGST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IGST_ASSERT(lbl, prop, msg)
`define IGST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/igst_pkg.sv */
// ---------------------------------------------------------------------------
// igst_pkg
// Types and constants shared by the inverse Gaussian sample transform.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package igst_pkg;

  localparam logic [31:0] MEAN_CAP = 32'd65536000;  // 1000.0 in Q16.16

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_SATURATED  = 2'd1;
  localparam logic [1:0] STATUS_SHAPE_ZERO = 2'd2;

  // Carried beside the square root cells.
  typedef struct packed {
    logic        lam_zero;
    logic        a_zero;
    logic [25:0] mean;
    logic [15:0] unif;
    logic [55:0] a;
    logic [83:0] num;
  } sq_side_t;

  // Carried beside the first divider cells.
  typedef struct packed {
    logic        lam_zero;
    logic        a_zero;
    logic [25:0] mean;
    logic [15:0] unif;
  } dv_side_t;

  // Carried beside the reflection divider cells.
  typedef struct packed {
    logic        lam_zero;
    logic        sel_x;
    logic        ovf;
    logic [25:0] x;
  } fd_side_t;

endpackage

/* hw/rtl/igst_sqrt_cell.sv */
// ---------------------------------------------------------------------------
// igst_sqrt_cell
// One digit of a bit-serial integer square root, registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module igst_sqrt_cell #(
  parameter int BIT = 0,
  parameter int DW  = 116,
  parameter int RW  = 58,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_v,
  input  logic [DW-1:0] in_rem,
  input  logic [RW-1:0] in_root,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [DW-1:0] out_rem,
  output logic [RW-1:0] out_root,
  output logic [SW-1:0] out_side
);

  localparam int TW = DW + 2;

  logic [TW-1:0] trial;
  logic          hit;
  logic [DW-1:0] rem_nxt;
  logic [RW-1:0] root_nxt;
  logic          v_r;
  logic [DW-1:0] rem_r;
  logic [RW-1:0] root_r;
  logic [SW-1:0] side_r;

  // With r the root so far, (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b).
  always_comb begin
    trial    = ({{(TW-RW){1'b0}}, in_root} << (BIT + 1)) | ({{(TW-1){1'b0}}, 1'b1} << (2 * BIT));
    hit      = {2'b00, in_rem} >= trial;
    rem_nxt  = hit ? in_rem - trial[DW-1:0] : in_rem;
    root_nxt = hit ? (in_root | ({{(RW-1){1'b0}}, 1'b1} << BIT)) : in_root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

  assign out_v    = v_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_side = side_r;

endmodule

/* hw/rtl/igst_div_cell.sv */
// ---------------------------------------------------------------------------
// igst_div_cell
// One quotient bit of a restoring divider, registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module igst_div_cell #(
  parameter int BIT = 0,
  parameter int NW  = 84,
  parameter int DW  = 59,
  parameter int QW  = 32,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_v,
  input  logic [NW-1:0] in_rem,
  input  logic [DW-1:0] in_div,
  input  logic [QW-1:0] in_quo,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [NW-1:0] out_rem,
  output logic [DW-1:0] out_div,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] sh;
  logic          hit;
  logic [NW-1:0] rem_nxt;
  logic [QW-1:0] quo_nxt;
  logic          v_r;
  logic [NW-1:0] rem_r;
  logic [DW-1:0] div_r;
  logic [QW-1:0] quo_r;
  logic [SW-1:0] side_r;

  always_comb begin
    sh      = {{(CW-DW){1'b0}}, in_div} << BIT;
    hit     = {{(CW-NW){1'b0}}, in_rem} >= sh;
    rem_nxt = hit ? in_rem - sh[NW-1:0] : in_rem;
    quo_nxt = hit ? (in_quo | ({{(QW-1){1'b0}}, 1'b1} << BIT)) : in_quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      div_r  <= in_div;
      quo_r  <= quo_nxt;
      side_r <= in_side;
    end
  end

  assign out_v    = v_r;
  assign out_rem  = rem_r;
  assign out_div  = div_r;
  assign out_quo  = quo_r;
  assign out_side = side_r;

endmodule

/* hw/rtl/inverse_gaussian_sample_transform.sv */
// ---------------------------------------------------------------------------
// inverse_gaussian_sample_transform
// Pipelined inverse Gaussian sampler built from a chain of root and
// divider cells.
// ---------------------------------------------------------------------------
// Usage: present mean, shape, normal and uniform draws on the in_ channel;
// a request is taken on a clock edge with in_valid high and in_stall low.
// One result per request leaves on the out_ channel in request order, with
// sample, reflection flag and status.
// Throughput is one request per cycle while in_stall is low. The path runs
// through six set-up stages, 58 square root cells, one stage, 32 divider
// cells, three stages, 32 reflection divider cells and the output register;
// the root and divider chains resolve one bit per cell.
// A skid register sits behind the output register. When the receiver holds
// out_stall and the skid register fills, in_stall rises and the whole chain
// holds its contents; nothing is dropped. The next request is still taken
// while a result waits, until the skid register is full.
// Reset (synchronous, rst_n low) clears every valid bit; results in flight
// are discarded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "inverse_gaussian_sample_transform_defines.svh"

module inverse_gaussian_sample_transform (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_mean_value,
  input  logic [31:0]        in_shape_value,
  input  logic signed [15:0] in_normal_draw,
  input  logic [15:0]        in_uniform_draw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_sample_value,
  output logic               out_took_reflected,
  output logic [1:0]         out_status
);

  localparam int SQ_SW = $bits(igst_pkg::sq_side_t);
  localparam int DV_SW = $bits(igst_pkg::dv_side_t);
  localparam int FD_SW = $bits(igst_pkg::fd_side_t);

  logic adv;
  logic skid_full_r;

  // Stage 1: clamp and magnitude.
  logic        v1_r, lz1_r;
  logic [25:0] m1_r;
  logic [31:0] lam1_r;
  logic [15:0] z1_r, u1_r;
  logic [15:0] zbits, zabs_nxt;
  logic [25:0] mclamp_nxt;

  always_comb begin
    zbits      = in_normal_draw;
    zabs_nxt   = zbits[15] ? 16'(~zbits + 16'd1) : zbits;
    mclamp_nxt = (in_mean_value > igst_pkg::MEAN_CAP) ? igst_pkg::MEAN_CAP[25:0]
                                                      : in_mean_value[25:0];
  end

  // Stage 2 and 3: y = z*z, a = M*y.
  logic        v2_r, lz2_r, v3_r, lz3_r;
  logic [25:0] m2_r, m3_r;
  logic [31:0] lam2_r, lam3_r;
  logic [15:0] u2_r, u3_r;
  logic [30:0] y2_r;
  logic [55:0] a3_r;
  logic [56:0] a_full;

  assign a_full = {31'b0, m2_r} * {26'b0, y2_r};

  // Stage 4: partial products on the halves of a.
  logic        v4_r, lz4_r, az4_r;
  logic [25:0] m4_r;
  logic [15:0] u4_r;
  logic [55:0] a4_r;
  logic [59:0] pla_l_r, pla_h_r;
  logic [55:0] paa_ll_r, paa_hl_r, paa_hh_r;
  logic [53:0] pma_l_r, pma_h_r;
  logic [27:0] al, ah;

  assign al = a3_r[27:0];
  assign ah = a3_r[55:28];

  // Stage 5 and 6: assemble D and the numerator.
  logic        v5_r, lz5_r, az5_r, v6_r;
  logic [25:0] m5_r;
  logic [15:0] u5_r;
  logic [55:0] a5_r;
  logic [87:0] lama5_r;
  logic [111:0] aa5_r;
  logic [83:0] num5_r;
  logic [115:0] d6_r;
  igst_pkg::sq_side_t side6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lz1_r  <= (in_shape_value == 32'd0);
      m1_r   <= mclamp_nxt;
      lam1_r <= in_shape_value;
      z1_r   <= zabs_nxt;
      u1_r   <= in_uniform_draw;

      lz2_r  <= lz1_r;
      m2_r   <= m1_r;
      lam2_r <= lam1_r;
      u2_r   <= u1_r;
      y2_r   <= 31'({16'b0, z1_r} * {16'b0, z1_r});

      lz3_r  <= lz2_r;
      m3_r   <= m2_r;
      lam3_r <= lam2_r;
      u3_r   <= u2_r;
      a3_r   <= a_full[55:0];

      lz4_r    <= lz3_r;
      az4_r    <= (a3_r == 56'd0);
      m4_r     <= m3_r;
      u4_r     <= u3_r;
      a4_r     <= a3_r;
      pla_l_r  <= {28'b0, lam3_r} * {32'b0, al};
      pla_h_r  <= {28'b0, lam3_r} * {32'b0, ah};
      paa_ll_r <= {28'b0, al} * {28'b0, al};
      paa_hl_r <= {28'b0, ah} * {28'b0, al};
      paa_hh_r <= {28'b0, ah} * {28'b0, ah};
      pma_l_r  <= {28'b0, m3_r} * {26'b0, al};
      pma_h_r  <= {28'b0, m3_r} * {26'b0, ah};

      lz5_r   <= lz4_r;
      az5_r   <= az4_r;
      m5_r    <= m4_r;
      u5_r    <= u4_r;
      a5_r    <= a4_r;
      lama5_r <= ({28'b0, pla_h_r} << 28) + {28'b0, pla_l_r};
      aa5_r   <= ({56'b0, paa_hh_r} << 56) + ({56'b0, paa_hl_r} << 29) + {56'b0, paa_ll_r};
      num5_r  <= (({30'b0, pma_h_r} << 28) + {30'b0, pma_l_r}) << 1;

      // D = 4*lambda*a aligned to the a*a scale, plus a*a.
      d6_r             <= ({28'b0, lama5_r} << 26) + {4'b0, aa5_r};
      side6_r.lam_zero <= lz5_r;
      side6_r.a_zero   <= az5_r;
      side6_r.mean     <= m5_r;
      side6_r.unif     <= u5_r;
      side6_r.a        <= a5_r;
      side6_r.num      <= num5_r;
    end
  end

  // Square root chain, most significant root bit first.
  logic              sq_v    [0:58];
  logic [115:0]      sq_rem  [0:58];
  logic [57:0]       sq_root [0:58];
  logic [SQ_SW-1:0]  sq_side [0:58];

  assign sq_v[0]    = v6_r;
  assign sq_rem[0]  = d6_r;
  assign sq_root[0] = 58'd0;
  assign sq_side[0] = side6_r;

  for (genvar g = 0; g < 58; g++) begin : g_sqrt
    igst_sqrt_cell #(.BIT(57 - g), .DW(116), .RW(58), .SW(SQ_SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_v     (sq_v[g]),
      .in_rem   (sq_rem[g]),
      .in_root  (sq_root[g]),
      .in_side  (sq_side[g]),
      .out_v    (sq_v[g+1]),
      .out_rem  (sq_rem[g+1]),
      .out_root (sq_root[g+1]),
      .out_side (sq_side[g+1])
    );
  end

  // Stage 7: divisor s + a.
  igst_pkg::sq_side_t sq_out;
  logic               v7_r;
  logic [58:0]        dv7_r;
  logic [83:0]        num7_r;
  igst_pkg::dv_side_t side7_r;

  assign sq_out = igst_pkg::sq_side_t'(sq_side[58]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= sq_v[58];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv7_r            <= {1'b0, sq_root[58]} + {3'b0, sq_out.a};
      num7_r           <= sq_out.num;
      side7_r.lam_zero <= sq_out.lam_zero;
      side7_r.a_zero   <= sq_out.a_zero;
      side7_r.mean     <= sq_out.mean;
      side7_r.unif     <= sq_out.unif;
    end
  end

  // Divider chain for q = 2*M*a / (s + a).
  logic              d1_v    [0:32];
  logic [83:0]       d1_rem  [0:32];
  logic [58:0]       d1_div  [0:32];
  logic [31:0]       d1_quo  [0:32];
  logic [DV_SW-1:0]  d1_side [0:32];

  assign d1_v[0]    = v7_r;
  assign d1_rem[0]  = num7_r;
  assign d1_div[0]  = dv7_r;
  assign d1_quo[0]  = 32'd0;
  assign d1_side[0] = side7_r;

  for (genvar g = 0; g < 32; g++) begin : g_div1
    igst_div_cell #(.BIT(31 - g), .NW(84), .DW(59), .QW(32), .SW(DV_SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_v     (d1_v[g]),
      .in_rem   (d1_rem[g]),
      .in_div   (d1_div[g]),
      .in_quo   (d1_quo[g]),
      .in_side  (d1_side[g]),
      .out_v    (d1_v[g+1]),
      .out_rem  (d1_rem[g+1]),
      .out_div  (d1_div[g+1]),
      .out_quo  (d1_quo[g+1]),
      .out_side (d1_side[g+1])
    );
  end

  // Stages 8 to 10: root x, acceptance test and reflection set-up.
  igst_pkg::dv_side_t d1_out;
  logic        v8_r, v9_r, v10_r;
  logic        lz8_r, lz9_r;
  logic [25:0] m8_r, m9_r, x8_r, x9_r;
  logic [15:0] u8_r;
  logic [25:0] x_nxt;
  logic [42:0] prod9_r;
  logic [51:0] mm9_r;
  logic [26:0] mx_sum;
  logic [51:0] mm10_r;
  logic [25:0] xd10_r;
  igst_pkg::fd_side_t side10_r;

  assign d1_out = igst_pkg::dv_side_t'(d1_side[32]);
  assign mx_sum = {1'b0, m8_r} + {1'b0, x8_r};

  // With a zero there is no root to take: x is the mean itself.
  always_comb begin
    if (d1_out.a_zero) begin
      x_nxt = d1_out.mean;
    end else if (d1_quo[32] <= {6'b0, d1_out.mean}) begin
      x_nxt = d1_out.mean - d1_quo[32][25:0];
    end else begin
      x_nxt = 26'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else if (adv) begin
      v8_r  <= d1_v[32];
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lz8_r <= d1_out.lam_zero;
      m8_r  <= d1_out.mean;
      u8_r  <= d1_out.unif;
      x8_r  <= x_nxt;

      lz9_r   <= lz8_r;
      m9_r    <= m8_r;
      x9_r    <= x8_r;
      prod9_r <= {27'b0, u8_r} * {16'b0, mx_sum};
      mm9_r   <= {26'b0, m8_r} * {26'b0, m8_r};

      side10_r.lam_zero <= lz9_r;
      side10_r.sel_x    <= (prod9_r <= {1'b0, m9_r, 16'b0});
      side10_r.ovf      <= (x9_r == 26'd0) || ({6'b0, mm9_r} >= {x9_r, 32'b0});
      side10_r.x        <= x9_r;
      mm10_r            <= mm9_r;
      xd10_r            <= x9_r;
    end
  end

  // Reflection divider chain for M*M / x.
  logic              d2_v    [0:32];
  logic [51:0]       d2_rem  [0:32];
  logic [25:0]       d2_div  [0:32];
  logic [31:0]       d2_quo  [0:32];
  logic [FD_SW-1:0]  d2_side [0:32];

  assign d2_v[0]    = v10_r;
  assign d2_rem[0]  = mm10_r;
  assign d2_div[0]  = xd10_r;
  assign d2_quo[0]  = 32'd0;
  assign d2_side[0] = side10_r;

  for (genvar g = 0; g < 32; g++) begin : g_div2
    igst_div_cell #(.BIT(31 - g), .NW(52), .DW(26), .QW(32), .SW(FD_SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_v     (d2_v[g]),
      .in_rem   (d2_rem[g]),
      .in_div   (d2_div[g]),
      .in_quo   (d2_quo[g]),
      .in_side  (d2_side[g]),
      .out_v    (d2_v[g+1]),
      .out_rem  (d2_rem[g+1]),
      .out_div  (d2_div[g+1]),
      .out_quo  (d2_quo[g+1]),
      .out_side (d2_side[g+1])
    );
  end

  // Result selection.
  igst_pkg::fd_side_t fd;
  logic        last_v;
  logic [31:0] res_sample;
  logic        res_refl;
  logic [1:0]  res_status;

  assign fd     = igst_pkg::fd_side_t'(d2_side[32]);
  assign last_v = d2_v[32];

  always_comb begin
    if (fd.lam_zero) begin
      res_sample = 32'd0;
      res_refl   = 1'b0;
      res_status = igst_pkg::STATUS_SHAPE_ZERO;
    end else if (fd.sel_x) begin
      res_sample = {6'b0, fd.x};
      res_refl   = 1'b0;
      res_status = igst_pkg::STATUS_OK;
    end else if (fd.ovf) begin
      res_sample = 32'hFFFF_FFFF;
      res_refl   = 1'b1;
      res_status = igst_pkg::STATUS_SATURATED;
    end else begin
      res_sample = d2_quo[32];
      res_refl   = 1'b1;
      res_status = igst_pkg::STATUS_OK;
    end
  end

  // Output register with a skid register behind it.
  logic        out_valid_r;
  logic [31:0] out_sample_r, skid_sample_r;
  logic        out_refl_r, skid_refl_r;
  logic [1:0]  out_status_r, skid_status_r;

  assign adv = !skid_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_valid_r && out_stall) begin
      if (adv && last_v) begin
        skid_full_r <= 1'b1;
      end
    end else if (skid_full_r) begin
      out_valid_r <= 1'b1;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= last_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_stall) begin
      if (adv && last_v) begin
        skid_sample_r <= res_sample;
        skid_refl_r   <= res_refl;
        skid_status_r <= res_status;
      end
    end else if (skid_full_r) begin
      out_sample_r <= skid_sample_r;
      out_refl_r   <= skid_refl_r;
      out_status_r <= skid_status_r;
    end else if (last_v) begin
      out_sample_r <= res_sample;
      out_refl_r   <= res_refl;
      out_status_r <= res_status;
    end
  end

  assign in_stall           = skid_full_r;
  assign out_valid          = out_valid_r;
  assign out_sample_value   = out_sample_r;
  assign out_took_reflected = out_refl_r;
  assign out_status         = out_status_r;

  `IGST_ASSERT(a_skid_has_out, skid_full_r |-> out_valid_r, "skid full with empty output")
  `IGST_ASSERT_NEXT(a_skid_drains, skid_full_r && !out_stall, out_valid_r && !skid_full_r, "skid did not drain")
  `IGST_ASSERT(a_shape_zero, (out_valid_r && out_status_r == igst_pkg::STATUS_SHAPE_ZERO) |-> (out_sample_r == 32'd0 && !out_refl_r), "bad shape zero result")
  `IGST_ASSERT(a_saturated, (out_valid_r && out_status_r == igst_pkg::STATUS_SATURATED) |-> (out_sample_r == 32'hFFFF_FFFF && out_refl_r), "bad saturated result")
  `IGST_ASSERT(a_root_bound, (out_valid_r && !out_refl_r && out_status_r == igst_pkg::STATUS_OK) |-> (out_sample_r <= igst_pkg::MEAN_CAP), "root above mean cap")

endmodule

/* bench/inverse_gaussian_sample_transform_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Inverse Gaussian sample transform checker
// Watches the request and result channels, predicts each sample with an
// exact integer model of the transform and compares results in order.
// ---------------------------------------------------------------------------
module inverse_gaussian_sample_transform_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [31:0]        in_mean_value,
  input  logic [31:0]        in_shape_value,
  input  logic signed [15:0] in_normal_draw,
  input  logic [15:0]        in_uniform_draw,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [31:0]        out_sample_value,
  input  logic               out_took_reflected,
  input  logic [1:0]         out_status,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] sample;
    logic        refl;
    logic [1:0]  status;
  } ig_sample_t;

  ig_sample_t samples_due[$];

  function automatic logic [63:0] isqrt128(logic [127:0] d);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= d) r = c;
    end
    return r;
  endfunction

  function automatic ig_sample_t sample_of(logic [31:0] mean_in, logic [31:0] lam,
                                           logic [15:0] z, logic [15:0] u);
    ig_sample_t res;
    logic [127:0] mu, za, y, a, d, s, num, q, x, refl_v;
    res = '0;
    if (lam == 0) begin
      res.status = igst_pkg::STATUS_SHAPE_ZERO;
      return res;
    end
    mu = (mean_in > igst_pkg::MEAN_CAP) ? igst_pkg::MEAN_CAP : mean_in;
    za = z[15] ? (128'h10000 - z) : z;
    y = za * za;
    a = mu * y;
    if (a == 0) begin
      x = mu;
    end else begin
      d = ((lam * a) << 26) + a * a;
      s = isqrt128(d);
      num = (mu * a) << 1;
      q = num / (s + a);
      x = (q <= mu) ? mu - q : 0;
    end
    res.status = igst_pkg::STATUS_OK;
    if (u * (mu + x) <= (mu << 16)) begin
      res.sample = x[31:0];
    end else begin
      res.refl = 1'b1;
      if (x == 0) begin
        res.sample = '1;
        res.status = igst_pkg::STATUS_SATURATED;
      end else begin
        refl_v = (mu * mu) / x;
        if (refl_v > 128'hFFFF_FFFF) begin
          res.sample = '1;
          res.status = igst_pkg::STATUS_SATURATED;
        end else begin
          res.sample = refl_v[31:0];
        end
      end
    end
    return res;
  endfunction

  assign pending = samples_due.size();

  always @(posedge clk) begin
    ig_sample_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      samples_due.delete();
    end else begin
      if (in_valid && !in_stall)
        samples_due.push_back(sample_of(in_mean_value, in_shape_value,
                                        in_normal_draw, in_uniform_draw));
      if (out_valid && !out_stall) begin
        if (samples_due.size() == 0) begin
          $error("result with no request waiting: sample %h", out_sample_value);
          errs = errs + 1;
        end else begin
          want = samples_due.pop_front();
          if (want.sample !== out_sample_value) begin
            $error("sample_value: expected %h, got %h", want.sample, out_sample_value);
            errs = errs + 1;
          end
          if (want.refl !== out_took_reflected) begin
            $error("took_reflected: expected %b, got %b", want.refl, out_took_reflected);
            errs = errs + 1;
          end
          if (want.status !== out_status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

/* bench/inverse_gaussian_sample_transform_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Inverse Gaussian sample transform testbench
// Drives directed corner requests and then random ones with random gaps and
// receiver stalls; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module inverse_gaussian_sample_transform_tb;

  localparam int LATENCY = 133;
  localparam int NUM_RANDOM = 1650;
  localparam longint CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        in_mean_value = '0;
  logic [31:0]        in_shape_value = '0;
  logic signed [15:0] in_normal_draw = '0;
  logic [15:0]        in_uniform_draw = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        out_sample_value;
  logic               out_took_reflected;
  logic [1:0]         out_status;
  int                 fail_count;
  int                 pending;
  longint             cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  inverse_gaussian_sample_transform uut (.*);
  inverse_gaussian_sample_transform_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("inverse_gaussian_sample_transform: mismatch");
      $finish;
    end
  end

  // Receiver stalls: a random run of stalled cycles, then a random run free.
  initial begin
    int n;
    forever begin
      n = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) n = 0;
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(logic [31:0] m, logic [31:0] l, logic [15:0] z,
                              logic [15:0] u, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mean_value <= m;
    in_shape_value <= l;
    in_normal_draw <= z;
    in_uniform_draw <= u;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_mean();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0001_0000);
      2: return $urandom_range(igst_pkg::MEAN_CAP - 100, igst_pkg::MEAN_CAP + 100);
      default: return $urandom_range(1, 32'h0100_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_shape();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return $urandom();
      2: return $urandom_range(1, 256);
      default: return $urandom_range(1, 32'h0100_0000);
    endcase
  endfunction

  function automatic logic [15:0] pick_normal();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 16'd0;
      default: return $urandom_range(0, 16'h2000) - 16'h1000;
    endcase
  endfunction

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(32'h0001_0000, 32'd0, 16'h1000, 16'h8000, 0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'hFFFF, 0);
    send_request(32'hFFFF_FFFF, 32'd1, 16'h8000, 16'hFFFF, 0);
    send_request(32'd0, 32'h0001_0000, 16'h1000, 16'h0000, 0);
    send_request(32'h0001_0000, 32'h0001_0000, 16'd0, 16'hFFFF, 0);
    send_request(igst_pkg::MEAN_CAP, 32'd1, 16'h7FFF, 16'hFFFF, 0);
    send_request(igst_pkg::MEAN_CAP + 1, 32'h0001_0000, 16'hF000, 16'h0000, 0);
    send_request(32'd1, 32'hFFFF_FFFF, 16'h0001, 16'hFFFF, 0);
    send_request(32'h0002_0000, 32'h0001_0000, 16'h1800, 16'hFFF0, 0);
    send_request(32'h0002_0000, 32'h0001_0000, 16'hE800, 16'h0010, 0);
    send_request(32'h0064_0000, 32'd1, 16'h4000, 16'hFFFF, 0);
    send_request(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 0);
    send_request(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555, 0);

    // Let the pipeline drain completely before the random part.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_request(pick_mean(), pick_shape(), pick_normal(), $urandom(),
                   (i % 200 < 60) ? 0 : $urandom_range(0, 7));
      if (i == NUM_RANDOM / 2) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    if (fail_count == 0) begin
      $display("inverse_gaussian_sample_transform: match");
    end else begin
      $display("inverse_gaussian_sample_transform: mismatch");
    end
    $finish;
  end
endmodule
